// ===== rtl/brsp_pkg.sv =====
// Shared types and constants for the block reward with size penalty pipeline.
// No dependencies.
`default_nettype none
package brsp_pkg;

	typedef enum logic [2:0] {
		REG_COIN_SUPPLY  = 3'd0,
		REG_SPEED_FACTOR = 3'd1,
		REG_TAIL_SUBSIDY = 3'd2,
		REG_TARGET_V1    = 3'd3,
		REG_TARGET_V2    = 3'd4,
		REG_ZONE_V1      = 3'd5,
		REG_ZONE_V2      = 3'd6,
		REG_ZONE_V5      = 3'd7
	} reg_idx_t;

	localparam logic [63:0] RST_COIN_SUPPLY  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [5:0]  RST_SPEED_FACTOR = 6'd20;
	localparam logic [63:0] RST_TAIL_SUBSIDY = 64'd300000000000;
	localparam logic [11:0] RST_TARGET_V1    = 12'd60;
	localparam logic [11:0] RST_TARGET_V2    = 12'd120;
	localparam logic [31:0] RST_ZONE_V1      = 32'd20000;
	localparam logic [31:0] RST_ZONE_V2      = 32'd60000;
	localparam logic [31:0] RST_ZONE_V5      = 32'd300000;

	localparam logic [7:0]  VER_V2 = 8'd2;
	localparam logic [7:0]  VER_V5 = 8'd5;

	// floor(t/60) = (t * 4370) >> 18 for all 12-bit t
	localparam logic [12:0] MIN_RECIP = 13'd4370;
	localparam int          MIN_SHIFT = 18;

	localparam int QUO_BITS = 64;

	typedef struct packed {
		logic [5:0]  speed_factor;
		logic [63:0] coin_supply;
		logic [63:0] tail_subsidy;
		logic [11:0] target_v1;
		logic [11:0] target_v2;
		logic [31:0] zone_v1;
		logic [31:0] zone_v2;
		logic [31:0] zone_v5;
	} cfg_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] lo;
		logic [63:0] dvs;
		logic        status;
	} div_t;

endpackage
`default_nettype wire

// ===== rtl/block_reward_with_size_penalty.sv =====
// Block reward with size penalty: config registers, front stages, 64-step divider.
// Depends on brsp_pkg, brsp_front, brsp_div_stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries med_weight, block_weight,
//   coins_issued and format_version; output channel (out_valid/out_ready)
//   returns reward_amount and status, one result per input, in order.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data);
//   write it only while the pipeline is empty.
//   Pipeline: 5 front stages, then 64 divider stages, one quotient bit each.
//   Throughput: one item per cycle while the output is not stalled; the
//   64-stage restoring divider for base*(2M-C)*C / M^2 sets the depth.
//   Stall: the whole pipeline holds while out_valid is high and out_ready low;
//   in_ready is low only then. Nothing is dropped or repeated.
//   Reset: all valid bits clear, config registers take their reset values.
`default_nettype none
module block_reward_with_size_penalty (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] med_weight,
	input  wire logic [31:0] block_weight,
	input  wire logic [63:0] coins_issued,
	input  wire logic [7:0]  format_version,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      reward_amount,
	output logic             status
);

	brsp_pkg::cfg_t cfg_q;
	logic           en;

	logic           v_pipe [brsp_pkg::QUO_BITS+1];
	brsp_pkg::div_t d_pipe [brsp_pkg::QUO_BITS+1];

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coin_supply  <= brsp_pkg::RST_COIN_SUPPLY;
			cfg_q.speed_factor <= brsp_pkg::RST_SPEED_FACTOR;
			cfg_q.tail_subsidy <= brsp_pkg::RST_TAIL_SUBSIDY;
			cfg_q.target_v1    <= brsp_pkg::RST_TARGET_V1;
			cfg_q.target_v2    <= brsp_pkg::RST_TARGET_V2;
			cfg_q.zone_v1      <= brsp_pkg::RST_ZONE_V1;
			cfg_q.zone_v2      <= brsp_pkg::RST_ZONE_V2;
			cfg_q.zone_v5      <= brsp_pkg::RST_ZONE_V5;
		end else if (cfg_we) begin
			unique case (brsp_pkg::reg_idx_t'(cfg_index))
				brsp_pkg::REG_COIN_SUPPLY:  cfg_q.coin_supply  <= cfg_data;
				brsp_pkg::REG_SPEED_FACTOR: cfg_q.speed_factor <= cfg_data[5:0];
				brsp_pkg::REG_TAIL_SUBSIDY: cfg_q.tail_subsidy <= cfg_data;
				brsp_pkg::REG_TARGET_V1:    cfg_q.target_v1    <= cfg_data[11:0];
				brsp_pkg::REG_TARGET_V2:    cfg_q.target_v2    <= cfg_data[11:0];
				brsp_pkg::REG_ZONE_V1:      cfg_q.zone_v1      <= cfg_data[31:0];
				brsp_pkg::REG_ZONE_V2:      cfg_q.zone_v2      <= cfg_data[31:0];
				brsp_pkg::REG_ZONE_V5:      cfg_q.zone_v5      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	brsp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.cfg            (cfg_q),
		.in_v           (in_valid),
		.med_weight     (med_weight),
		.block_weight   (block_weight),
		.coins_issued   (coins_issued),
		.format_version (format_version),
		.out_v          (v_pipe[0]),
		.out_d          (d_pipe[0])
	);

	for (genvar i = 0; i < brsp_pkg::QUO_BITS; i++) begin : g_div
		brsp_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (v_pipe[i]),
			.in_d   (d_pipe[i]),
			.out_v  (v_pipe[i+1]),
			.out_d  (d_pipe[i+1])
		);
	end

	assign out_valid     = v_pipe[brsp_pkg::QUO_BITS];
	assign reward_amount = d_pipe[brsp_pkg::QUO_BITS].status ? 64'd0
	                     : d_pipe[brsp_pkg::QUO_BITS].lo;
	assign status        = d_pipe[brsp_pkg::QUO_BITS].status;

endmodule
`default_nettype wire

// ===== rtl/brsp_front.sv =====
// Front stages: base reward, penalty multiplier, divisor and 128-bit product.
// Depends on brsp_pkg.
`default_nettype none
module brsp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire brsp_pkg::cfg_t cfg,
	input  wire logic           in_v,
	input  wire logic [31:0]    med_weight,
	input  wire logic [31:0]    block_weight,
	input  wire logic [63:0]    coins_issued,
	input  wire logic [7:0]     format_version,
	output logic                out_v,
	output brsp_pkg::div_t      out_d
);

	logic        ver_lo, ver_mid;
	logic [11:0] tgt;
	logic [31:0] zone;
	logic [24:0] min_prod;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [6:0]  min_s1;
	logic [31:0] med_s1, wt_s1;
	logic [63:0] rem_s1;

	logic signed [7:0] sh;
	logic [63:0] base_sh_s2, flr_s2, msq_s2;
	logic        le_s2, big_s2;
	logic [31:0] diff_s2, wt_s2;

	logic [63:0] base_s3, mult_s3, dvs_s3;
	logic        big_s3;

	logic [63:0] p00_s4, p01_s4, p10_s4, p11_s4, dvs_s4;
	logic        big_s4;

	logic [127:0] prod;

	always_comb begin
		ver_lo   = format_version < brsp_pkg::VER_V2;
		ver_mid  = format_version < brsp_pkg::VER_V5;
		tgt      = ver_lo ? cfg.target_v1 : cfg.target_v2;
		zone     = ver_lo ? cfg.zone_v1 : (ver_mid ? cfg.zone_v2 : cfg.zone_v5);
		min_prod = {13'd0, tgt} * {12'd0, brsp_pkg::MIN_RECIP};
		sh       = $signed({2'b00, cfg.speed_factor}) - $signed({1'b0, min_s1}) + 8'sd1;
		prod     = {64'd0, p00_s4} + {32'd0, p01_s4, 32'd0} + {32'd0, p10_s4, 32'd0}
		         + {p11_s4, 64'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			min_s1 <= min_prod[24:brsp_pkg::MIN_SHIFT];
			med_s1 <= (med_weight < zone) ? zone : med_weight;
			wt_s1  <= block_weight;
			rem_s1 <= cfg.coin_supply - coins_issued;

			if (sh < 0)
				base_sh_s2 <= rem_s1;
			else if (sh > 8'sd63)
				base_sh_s2 <= 64'd0;
			else
				base_sh_s2 <= rem_s1 >> sh[5:0];
			flr_s2  <= 64'(cfg.tail_subsidy * {57'd0, min_s1});
			le_s2   <= wt_s1 <= med_s1;
			big_s2  <= {1'b0, wt_s1} > {med_s1, 1'b0};
			diff_s2 <= 32'({med_s1, 1'b0} - {1'b0, wt_s1});
			wt_s2   <= wt_s1;
			msq_s2  <= {32'd0, med_s1} * {32'd0, med_s1};

			base_s3 <= (base_sh_s2 < flr_s2) ? flr_s2 : base_sh_s2;
			big_s3  <= big_s2;
			if (le_s2) begin
				mult_s3 <= 64'd1;
				dvs_s3  <= 64'd1;
			end else if (big_s2) begin
				mult_s3 <= 64'd0;
				dvs_s3  <= 64'd1;
			end else begin
				mult_s3 <= {32'd0, diff_s2} * {32'd0, wt_s2};
				dvs_s3  <= msq_s2;
			end

			p00_s4 <= {32'd0, base_s3[31:0]}  * {32'd0, mult_s3[31:0]};
			p01_s4 <= {32'd0, base_s3[31:0]}  * {32'd0, mult_s3[63:32]};
			p10_s4 <= {32'd0, base_s3[63:32]} * {32'd0, mult_s3[31:0]};
			p11_s4 <= {32'd0, base_s3[63:32]} * {32'd0, mult_s3[63:32]};
			dvs_s4 <= dvs_s3;
			big_s4 <= big_s3;

			out_d.rem    <= prod[127:64];
			out_d.lo     <= prod[63:0];
			out_d.dvs    <= dvs_s4;
			out_d.status <= big_s4;
		end
	end

	assign out_v = v_s5;

endmodule
`default_nettype wire

// ===== rtl/brsp_div_stage.sv =====
// One restoring-division step: one quotient bit per stage.
// Depends on brsp_pkg.
`default_nettype none
module brsp_div_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_v,
	input  wire brsp_pkg::div_t in_d,
	output logic                out_v,
	output brsp_pkg::div_t      out_d
);

	logic [64:0] r2, sub;
	logic        ge;

	always_comb begin
		r2  = {in_d.rem, in_d.lo[63]};
		sub = r2 - {1'b0, in_d.dvs};
		ge  = r2 >= {1'b0, in_d.dvs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v <= 1'b0;
		else if (en)
			out_v <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d.rem    <= ge ? sub[63:0] : r2[63:0];
			out_d.lo     <= {in_d.lo[62:0], ge};
			out_d.dvs    <= in_d.dvs;
			out_d.status <= in_d.status;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/brsp_checker.sv =====
// Port-level checks for block_reward_with_size_penalty, bound to the top level.
// Depends on the top-level ports only.
`default_nettype none
module brsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] reward_amount,
	input wire logic        status
);

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not track output stall");

	a_too_big_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> reward_amount == 64'd0)
		else $error("too-big status with nonzero reward");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reward_amount) && $stable(status))
		else $error("stalled result changed");

endmodule

bind block_reward_with_size_penalty brsp_checker u_brsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.reward_amount (reward_amount),
	.status        (status)
);
`default_nettype wire
